// ===== rtl/sspq_pkg.sv =====
package sspq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] density;
    logic [15:0] tag;
    logic [7:0]  action_code;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_density;
    logic [15:0] out_tag;
    logic [7:0]  out_action;
    logic [4:0]  fill_level;
  } out_item_t;

  typedef struct packed {
    logic [15:0] density;
    logic [15:0] tag;
    logic [7:0]  action;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_TAKE,
    S_INS_CMP,
    S_INS_PUT,
    S_RESULT
  } seq_state_t;

endpackage

// ===== rtl/sspq_mem.sv =====
module sspq_mem #(
  parameter int QUEUE_DEPTH = sspq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  sspq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output sspq_pkg::entry_t rdata
);
  import sspq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sspq_seq.sv =====
module sspq_seq #(
  parameter int QUEUE_DEPTH = sspq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sspq_pkg::in_item_t  in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output sspq_pkg::out_item_t res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output sspq_pkg::entry_t    mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  sspq_pkg::entry_t    mem_rdata
);
  import sspq_pkg::*;

  localparam logic [AW:0] DEPTH_V = (AW + 1)'(QUEUE_DEPTH);

  seq_state_t    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] k_r, k_nxt;
  entry_t        new_r, new_nxt;
  status_t       res_status_r, res_status_nxt;
  entry_t        res_ent_r, res_ent_nxt;
  logic [AW-1:0] rd_off;
  logic [AW-1:0] head_inc;
  logic          shift;

  // Logical slot offset from the head, folded back into the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
  end

  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign shift    = mem_rdata.density < new_r.density;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    rd_off         = '0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = new_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // The read port looks ahead: the head for a pop, the tail for an insert.
        if (in_data.mode == MODE_INSERT) begin
          rd_off = AW'(count_r - 1'b1);
        end
        if (in_valid) begin
          new_nxt = '{density: in_data.density, tag: in_data.tag,
                      action: in_data.action_code};
          k_nxt   = AW'(count_r);
          if (in_data.mode == MODE_POP) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              res_ent_nxt    = '0;
              state_nxt      = S_RESULT;
            end else begin
              state_nxt = S_POP_TAKE;
            end
          end else if (count_r == CW'(QUEUE_DEPTH)) begin
            res_status_nxt = ST_FULL;
            res_ent_nxt    = '0;
            state_nxt      = S_RESULT;
          end else if (count_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            state_nxt = S_INS_CMP;
          end
        end
      end
      S_POP_TAKE: begin
        res_status_nxt = ST_OK;
        res_ent_nxt    = mem_rdata;
        head_nxt       = head_inc;
        count_nxt      = count_r - 1'b1;
        state_nxt      = S_RESULT;
      end
      S_INS_CMP: begin
        // Slot k-1 is on the read port; it either moves down to slot k or
        // the new entry lands at slot k behind it.
        mem_we = 1'b1;
        if (shift) begin
          mem_wdata = mem_rdata;
          if (k_r == AW'(1)) begin
            k_nxt     = '0;
            state_nxt = S_INS_PUT;
          end else begin
            rd_off = k_r - 1'b1 - 1'b1;
            k_nxt  = k_r - 1'b1;
          end
        end else begin
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_OK;
          res_ent_nxt    = '0;
          state_nxt      = S_RESULT;
        end
      end
      S_INS_PUT: begin
        mem_we         = 1'b1;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = ST_OK;
        res_ent_nxt    = '0;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mem_raddr = phys(head_r, rd_off);
  assign mem_waddr = phys(head_r, k_r);

  assign res = '{status: res_status_r, out_density: res_ent_r.density,
                 out_tag: res_ent_r.tag, out_action: res_ent_r.action,
                 fill_level: 5'(count_r)};

endmodule

// ===== rtl/stable_sorted_priority_queue.sv =====
// Channel  Ports                            Carries
// in       in_valid, in_ready, in_data      insert or pop request (in_item_t)
// out      out_valid, out_ready, out_data   status, popped entry, fill level
//
// A pop passes through S_POP_TAKE, an insert that moves no entry through S_INS_CMP (or
// S_INS_PUT on an empty queue); each then waits in S_RESULT until its result is taken
// into the output register. An insert that moves entries stays in S_INS_CMP while the
// stored entries of smaller density move back one slot, one per cycle through the entry
// memory and its comparator. A pop on an empty queue or a refused insert goes straight
// to S_RESULT. in_ready is high only while the sequencer is idle. Reset (rst_n low at a
// clock edge) empties the queue; slot contents are kept. A stalled result waits in the
// output register; the next item is taken once the sequencer has handed its result over.
module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH = sspq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sspq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sspq_pkg::out_item_t out_data
);
  import sspq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          res_valid;
  logic          res_ready;
  out_item_t     res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  sspq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  sspq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/sspq_checker.sv =====
module sspq_checker #(
  parameter int QUEUE_DEPTH = sspq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sspq_pkg::out_item_t out_data
);
  import sspq_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The queue works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in progress");

  // Refusals carry no entry. Inserts carry none either, but share ST_OK with pops and are not checked here.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.out_density == '0 && out_data.out_tag == '0 &&
      out_data.out_action == '0)
    else $error("entry fields set on a result without a popped entry");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.fill_level == 5'(QUEUE_DEPTH))
    else $error("full status with a fill level below the depth");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.fill_level == '0)
    else $error("empty status with entries stored");

endmodule

bind stable_sorted_priority_queue sspq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sspq_checker (.*);

// ===== dv/stable_sorted_priority_queue_tb.sv =====
module stable_sorted_priority_queue_tb;
  import sspq_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_LEN   = 25;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the queue contents, updated at each input transfer.
  entry_t    shadow_slot [QUEUE_DEPTH];
  int        shadow_count = 0;
  out_item_t pending_results [$];
  bit        pending_is_pop [$];

  bit no_idle = 1'b0;
  int error_count = 0;
  int requests_taken = 0;
  int stored_inserts = 0;
  int full_refusals = 0;
  int good_pops = 0;
  int empty_pops = 0;
  int quiet_cycles = 0;

  stable_sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t apply_to_shadow(in_item_t req);
    out_item_t res;
    int slot;
    res = '0;
    res.status = ST_OK;
    if (req.mode == MODE_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // New entry goes behind every entry of greater or equal density.
        slot = 0;
        while (slot < shadow_count && shadow_slot[slot].density >= req.density) slot++;
        for (int i = shadow_count; i > slot; i--) shadow_slot[i] = shadow_slot[i - 1];
        shadow_slot[slot] = '{density: req.density, tag: req.tag, action: req.action_code};
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.out_density = shadow_slot[0].density;
      res.out_tag     = shadow_slot[0].tag;
      res.out_action  = shadow_slot[0].action;
      for (int i = 1; i < shadow_count; i++) shadow_slot[i - 1] = shadow_slot[i];
      shadow_count--;
    end
    res.fill_level = 5'(shadow_count);
    return res;
  endfunction

  function automatic in_item_t make_request(logic mode, logic [15:0] density,
                                            logic [15:0] tag, logic [7:0] action);
    in_item_t it;
    it.mode        = mode;
    it.density     = density;
    it.tag         = tag;
    it.action_code = action;
    return it;
  endfunction

  function automatic in_item_t random_request(int pop_pct);
    in_item_t it;
    it.mode = ($urandom_range(0, 99) < pop_pct) ? MODE_POP : MODE_INSERT;
    // Keys cluster near both ends so that ties are common.
    case ($urandom_range(0, 3))
      0: it.density = 16'($urandom_range(0, 3));
      1: it.density = 16'hFFFF - 16'($urandom_range(0, 3));
      default: it.density = 16'($urandom);
    endcase
    it.tag         = 16'($urandom);
    it.action_code = 8'($urandom);
    return it;
  endfunction

  // Leaves in_valid high after the transfer so that a back-to-back request
  // needs no second assignment in the same step.
  task automatic send_request(in_item_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : result_checker
    out_item_t want;
    bit        was_pop;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_to_shadow(in_data));
        pending_is_pop.push_back(in_data.mode == MODE_POP);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_data.status);
          error_count++;
        end else begin
          want    = pending_results.pop_front();
          was_pop = pending_is_pop.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.out_density !== want.out_density) begin
            $error("out_density: expected %h, got %h", want.out_density, out_data.out_density);
            error_count++;
          end
          if (out_data.out_tag !== want.out_tag) begin
            $error("out_tag: expected %h, got %h", want.out_tag, out_data.out_tag);
            error_count++;
          end
          if (out_data.out_action !== want.out_action) begin
            $error("out_action: expected %h, got %h", want.out_action, out_data.out_action);
            error_count++;
          end
          if (out_data.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, out_data.fill_level);
            error_count++;
          end
          case (want.status)
            ST_FULL:  full_refusals++;
            ST_EMPTY: empty_pops++;
            default: begin
              if (was_pop) good_pops++;
              else stored_inserts++;
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("stable_sorted_priority_queue_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_pop_on_empty();
    send_request(make_request(MODE_POP, 16'hFFFF, 16'hFFFF, 8'hFF));
    wait_drained();
  endtask

  // Fills every slot with extremes and runs of equal density, then one more.
  task automatic test_fill_past_capacity();
    logic [15:0] dens_list [17] = '{16'h0005, 16'hFFFF, 16'h0000, 16'h0005, 16'h8000,
                                    16'h0005, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000,
                                    16'h0001, 16'hFFFE, 16'h0005, 16'h0000, 16'hFFFF,
                                    16'h1234, 16'hFFFF};
    no_idle = 1'b1;
    for (int i = 0; i < 17; i++) begin
      send_request(make_request(MODE_INSERT, dens_list[i],
                                (i == 1) ? 16'hFFFF : 16'(i),
                                (i == 1) ? 8'hFF : 8'(i * 3)));
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_in_order();
    for (int i = 0; i < 6; i++) begin
      send_request(make_request(MODE_POP, 16'(i), 16'hFFFF - 16'(i), 8'(i)));
    end
    wait_drained();
  endtask

  // Rounds of insert-heavy, pop-heavy and balanced traffic push the queue
  // against both the full and the empty limit many times.
  task automatic test_mixed_traffic(int rounds);
    int pop_pct;
    for (int r = 0; r < rounds; r++) begin
      no_idle = (r == 2);
      for (int p = 0; p < 3; p++) begin
        pop_pct = (p == 0) ? 10 : (p == 1) ? 90 : 50;
        for (int n = 0; n < PHASE_LEN; n++) send_request(random_request(pop_pct));
      end
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pop_on_empty();
    test_fill_past_capacity();
    test_drain_in_order();
    test_mixed_traffic(6);
    repeat (40) @(posedge clk);
    $display("%0d requests checked: %0d inserts stored, %0d refused when full,",
             requests_taken, stored_inserts, full_refusals);
    $display("%0d entries popped, %0d pops found the queue empty", good_pops, empty_pops);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("stable_sorted_priority_queue_tb: PASS");
    end else begin
      $display("stable_sorted_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sspq_pkg.sv
rtl/sspq_mem.sv
rtl/sspq_seq.sv
rtl/stable_sorted_priority_queue.sv
rtl/sspq_checker.sv
dv/stable_sorted_priority_queue_tb.sv
